// ----- rtl/three_register_alu_executor_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the three-register ALU executor
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef THREE_REGISTER_ALU_EXECUTOR_CORE_ASSERT_SVH
`define THREE_REGISTER_ALU_EXECUTOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted
`define TRAE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define TRAE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TRAE_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define TRAE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/trae_pkg.sv -----
// ---------------------------------------------------------------------------
// trae_pkg
// Shared constants, types and operation codes of the ALU executor.
// ---------------------------------------------------------------------------
package trae_pkg;

    localparam int NUM_REGS   = 3;
    localparam int DATA_WIDTH = 32;
    localparam int REG_IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [REG_IDX_W-1:0]  reg_idx_t;

    // Operation codes carried in the kind field; code 7 is unused
    localparam logic [2:0] OP_MOV = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;
    localparam logic [2:0] OP_AND = 3'd5;
    localparam logic [2:0] OP_OR  = 3'd6;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic err;
    } alu_rsp_t;

endpackage

// ----- rtl/trae_serial_alu.sv -----
// ---------------------------------------------------------------------------
// trae_serial_alu
// Bit-serial ALU: one bit of the operands per cycle for move, add, subtract,
// AND and OR; shift-add multiply and restoring divide, one bit per cycle.
// ---------------------------------------------------------------------------
module trae_serial_alu (
    input  logic               aclk,
    input  logic               aresetn,
    input  trae_pkg::alu_req_t req,
    input  trae_pkg::word_t    a_i,
    input  trae_pkg::word_t    b_i,
    output trae_pkg::alu_rsp_t rsp,
    output trae_pkg::word_t    result
);

    localparam int W = trae_pkg::DATA_WIDTH;

    typedef enum logic [1:0] {
        U_IDLE,
        U_RUN,
        U_FIX
    } ustate_t;

    ustate_t                    ustate_reg;
    logic [2:0]                 op_reg;
    trae_pkg::word_t            x_reg;
    trae_pkg::word_t            y_reg;
    trae_pkg::word_t            acc_reg;
    trae_pkg::word_t            rem_reg;
    logic [trae_pkg::CNT_W-1:0] cnt_reg;
    logic                       carry_reg;
    logic                       neg_reg;
    logic                       err_reg;
    logic                       done_reg;

    logic            xb;
    logic            yn;
    logic            sbit;
    logic            cout;
    trae_pkg::word_t mul_sum;
    logic [W:0]      rs;
    logic [W:0]      diff;
    trae_pkg::word_t a_mag;
    trae_pkg::word_t b_mag;

    always_comb begin
        xb      = x_reg[0];
        yn      = (op_reg == trae_pkg::OP_SUB) ? ~y_reg[0] : y_reg[0];
        cout    = (xb & yn) | (carry_reg & (xb ^ yn));
        mul_sum = acc_reg + x_reg;
        rs      = {rem_reg, x_reg[W-1]};
        diff    = rs - {1'b0, y_reg};
        a_mag   = a_i[W-1] ? (~a_i + 1'b1) : a_i;
        b_mag   = b_i[W-1] ? (~b_i + 1'b1) : b_i;
        case (op_reg)
            trae_pkg::OP_MOV: sbit = y_reg[0];
            trae_pkg::OP_ADD: sbit = xb ^ yn ^ carry_reg;
            trae_pkg::OP_SUB: sbit = xb ^ yn ^ carry_reg;
            trae_pkg::OP_AND: sbit = xb & y_reg[0];
            trae_pkg::OP_OR:  sbit = xb | y_reg[0];
            default:          sbit = xb;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ustate_reg <= U_IDLE;
            done_reg   <= 1'b0;
            err_reg    <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (ustate_reg)
                U_IDLE: begin
                    if (req.start) begin
                        op_reg    <= req.op;
                        cnt_reg   <= trae_pkg::CNT_W'(W - 1);
                        carry_reg <= (req.op == trae_pkg::OP_SUB);
                        rem_reg   <= '0;
                        err_reg   <= 1'b0;
                        neg_reg   <= 1'b0;
                        x_reg     <= a_i;
                        y_reg     <= b_i;
                        acc_reg   <= '0;
                        ustate_reg <= U_RUN;
                        if (req.op == trae_pkg::OP_DIV) begin
                            if (b_i == '0) begin
                                // zero divisor: hand back the destination as is
                                err_reg    <= 1'b1;
                                acc_reg    <= a_i;
                                ustate_reg <= U_FIX;
                            end else begin
                                x_reg   <= a_mag;
                                y_reg   <= b_mag;
                                neg_reg <= a_i[W-1] ^ b_i[W-1];
                            end
                        end
                    end
                end
                U_RUN: begin
                    case (op_reg)
                        trae_pkg::OP_MUL: begin
                            if (y_reg[0]) begin
                                acc_reg <= mul_sum;
                            end
                            x_reg <= {x_reg[W-2:0], 1'b0};
                            y_reg <= {1'b0, y_reg[W-1:1]};
                        end
                        trae_pkg::OP_DIV: begin
                            // restore when the trial subtract goes negative
                            rem_reg <= diff[W] ? rs[W-1:0] : diff[W-1:0];
                            acc_reg <= {acc_reg[W-2:0], ~diff[W]};
                            x_reg   <= {x_reg[W-2:0], 1'b0};
                        end
                        default: begin
                            acc_reg   <= {sbit, acc_reg[W-1:1]};
                            x_reg     <= {1'b0, x_reg[W-1:1]};
                            y_reg     <= {1'b0, y_reg[W-1:1]};
                            carry_reg <= cout;
                        end
                    endcase
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        ustate_reg <= U_FIX;
                    end
                end
                U_FIX: begin
                    if (neg_reg) begin
                        acc_reg <= ~acc_reg + 1'b1;
                    end
                    done_reg   <= 1'b1;
                    ustate_reg <= U_IDLE;
                end
                default: ustate_reg <= U_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.err  = err_reg;
    assign result   = acc_reg;

endmodule

// ----- rtl/three_register_alu_executor_core.sv -----
// ---------------------------------------------------------------------------
// three_register_alu_executor_core
// Executes decoded instructions on a small register file with a bit-serial
// ALU and returns the destination's new value for each transaction.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | kind, dest_reg, src_is_reg, src_reg, immediate
//  m_      | out       | m_valid / m_ready  | dest_value, divide_error
//
// One transaction at a time: the serial ALU steps one operand bit per cycle after the
// register-file read and start, then does sign fix-up and writeback; a zero divisor skips
// the stepping. s_ready returns in the same cycle the result is loaded into the output register.
// Reset clears the register file at once through per-entry valid bits.
// A stalled result holds in the output register; the next transaction can be
// accepted meanwhile, and a finished result waits in the ALU until the slot frees.
// ---------------------------------------------------------------------------
`include "three_register_alu_executor_core_assert.svh"

module three_register_alu_executor_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_kind,
    input  logic [1:0]         s_dest_reg,
    input  logic               s_src_is_reg,
    input  logic [1:0]         s_src_reg,
    input  logic signed [31:0] s_immediate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_dest_value,
    output logic               m_divide_error
);

    localparam int NREGS = trae_pkg::NUM_REGS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_BUSY,
        ST_HOLD
    } state_t;

    state_t                state_reg;
    logic [2:0]            kind_reg;
    trae_pkg::reg_idx_t    dst_idx_reg;
    logic                  dst_ok_reg;
    logic                  src_is_reg_reg;
    trae_pkg::word_t       imm_reg;
    trae_pkg::word_t       rd_a_reg;
    trae_pkg::word_t       rd_b_reg;
    logic                  va_reg;
    logic                  vb_reg;
    logic                  m_valid_reg;
    logic signed [31:0]    m_dest_value_reg;
    logic                  m_divide_error_reg;

    trae_pkg::word_t       rf_mem [NREGS];
    logic [NREGS-1:0]      rf_valid_reg;

    trae_pkg::reg_idx_t    dst_idx;
    trae_pkg::reg_idx_t    src_idx;
    logic                  dst_ok;
    logic                  src_ok;
    logic                  accept;
    logic                  slot_free;
    logic                  load;
    logic                  rf_we;
    trae_pkg::word_t       a_op;
    trae_pkg::word_t       b_op;
    trae_pkg::alu_req_t    alu_req;
    trae_pkg::alu_rsp_t    alu_rsp;
    trae_pkg::word_t       alu_result;

    assign dst_idx   = trae_pkg::reg_idx_t'(s_dest_reg);
    assign src_idx   = trae_pkg::reg_idx_t'(s_src_reg);
    assign dst_ok    = int'(s_dest_reg) < NREGS;
    assign src_ok    = int'(s_src_reg) < NREGS;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign load      = ((state_reg == ST_BUSY && alu_rsp.done) || state_reg == ST_HOLD)
                       && slot_free;
    assign rf_we     = load && dst_ok_reg;

    // entries never written since reset read as zero
    assign a_op = va_reg ? rd_a_reg : '0;
    assign b_op = src_is_reg_reg ? (vb_reg ? rd_b_reg : '0) : imm_reg;

    assign alu_req.start = (state_reg == ST_READ);
    assign alu_req.op    = kind_reg;

    trae_serial_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a_i     (a_op),
        .b_i     (b_op),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    // register file: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[dst_idx_reg] <= alu_result;
        end
        if (accept) begin
            rd_a_reg <= rf_mem[dst_idx];
            rd_b_reg <= rf_mem[src_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            rf_valid_reg <= '0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
        end else begin
            if (rf_we) begin
                rf_valid_reg[dst_idx_reg] <= 1'b1;
            end
            if (load) begin
                m_valid_reg        <= 1'b1;
                m_dest_value_reg   <= dst_ok_reg ? signed'(32'(alu_result)) : '0;
                m_divide_error_reg <= alu_rsp.err;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        kind_reg       <= s_kind;
                        dst_idx_reg    <= dst_idx;
                        dst_ok_reg     <= dst_ok;
                        src_is_reg_reg <= s_src_is_reg;
                        imm_reg        <= trae_pkg::word_t'(s_immediate);
                        va_reg         <= dst_ok && rf_valid_reg[dst_idx];
                        vb_reg         <= src_ok && rf_valid_reg[src_idx];
                        state_reg      <= ST_READ;
                    end
                end
                ST_READ: state_reg <= ST_BUSY;
                ST_BUSY: begin
                    if (alu_rsp.done) begin
                        state_reg <= slot_free ? ST_IDLE : ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (slot_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_dest_value   = m_dest_value_reg;
    assign m_divide_error = m_divide_error_reg;

    `TRAE_ASSERT_CLK(a_one_in_flight, aclk, aresetn,
        (s_valid && s_ready) |=> !s_ready,
        "transaction accepted while another is in flight")
    `TRAE_ASSERT_CLK(a_done_when_busy, aclk, aresetn,
        alu_rsp.done |-> (state_reg == ST_BUSY),
        "ALU finished while the controller was not waiting")
    `TRAE_ASSERT_CLK(a_result_from_alu, aclk, aresetn,
        $rose(m_valid) |-> ($past(state_reg) == ST_BUSY || $past(state_reg) == ST_HOLD),
        "result presented without a finished ALU run")
    `TRAE_ASSERT_ALWAYS(a_reset_clears_valid, aclk,
        !aresetn |=> (rf_valid_reg == '0 && !m_valid),
        "reset left register or output valid state set")

endmodule

// ----- tb/three_register_alu_executor_core_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// three_register_alu_executor_core_tb
// Drives decoded instructions into the executor and checks every returned
// destination value and divide error flag. It does this against its own model
// of the three-entry register file. Covers the wrap cases, the divide corner
// cases, out-of-range register indexes, and both sides stalling.
// ---------------------------------------------------------------------------
module three_register_alu_executor_core_tb;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic [1:0] R1 = 2'd0;
    localparam logic [1:0] R2 = 2'd1;
    localparam logic [1:0] R3 = 2'd2;
    localparam logic [1:0] R_NONE = 2'd3;
    localparam logic SRC_IMM = 1'b0;
    localparam logic SRC_REG = 1'b1;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  dest_reg;
        logic        src_is_reg;
        logic [1:0]  src_reg;
        logic [31:0] immediate;
    } instr_t;

    typedef struct packed {
        logic [31:0] dest_value;
        logic        divide_error;
    } writeback_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_kind = '0;
    logic [1:0]         s_dest_reg = '0;
    logic               s_src_is_reg = 1'b0;
    logic [1:0]         s_src_reg = '0;
    logic signed [31:0] s_immediate = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_dest_value;
    logic               m_divide_error;

    trae_pkg::word_t shadow_regs [trae_pkg::NUM_REGS];
    writeback_t pending_writebacks [$];
    int         mismatch_count = 0;
    int         burst_left = 0;
    bit         sender_steady = 1'b0;
    bit         hold_req = 1'b0;
    int         hold_left = 0;
    int         stall_mode = 0;
    int         stall_mode_left = 0;
    int         stall_phase = 0;
    int         idle_cycles = 0;

    three_register_alu_executor_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_dest_reg     (s_dest_reg),
        .s_src_is_reg   (s_src_is_reg),
        .s_src_reg      (s_src_reg),
        .s_immediate    (s_immediate),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dest_value   (m_dest_value),
        .m_divide_error (m_divide_error)
    );

    always #6 aclk = ~aclk;

    function automatic instr_t make_instr(logic [2:0] kind, logic [1:0] dest,
                                          logic is_reg, logic [1:0] src,
                                          logic [31:0] imm);
        instr_t it;
        it.kind = kind;
        it.dest_reg = dest;
        it.src_is_reg = is_reg;
        it.src_reg = src;
        it.immediate = imm;
        return it;
    endfunction

    // Execute one instruction on the shadow register file and return the writeback
    function automatic writeback_t execute_instr(instr_t it);
        writeback_t wb;
        trae_pkg::word_t a, b, r, mag_a, mag_b;
        logic dvalid, err, wr;
        dvalid = (it.dest_reg < trae_pkg::NUM_REGS);
        err = 1'b0;
        wr = 1'b1;
        a = '0;
        b = it.immediate;
        if (it.src_is_reg)
            b = (it.src_reg < trae_pkg::NUM_REGS) ? shadow_regs[it.src_reg] : '0;
        if (dvalid)
            a = shadow_regs[it.dest_reg];
        case (it.kind)
            trae_pkg::OP_MOV: r = b;
            trae_pkg::OP_ADD: r = a + b;
            trae_pkg::OP_SUB: r = a - b;
            trae_pkg::OP_MUL: r = a * b;
            trae_pkg::OP_DIV: begin
                if (b == '0) begin
                    err = 1'b1;
                    wr = 1'b0;
                    r = a;
                end else begin
                    // divide magnitudes, then fix the sign: truncates toward zero
                    mag_a = a[trae_pkg::DATA_WIDTH-1] ? -a : a;
                    mag_b = b[trae_pkg::DATA_WIDTH-1] ? -b : b;
                    r = mag_a / mag_b;
                    if (a[trae_pkg::DATA_WIDTH-1] ^ b[trae_pkg::DATA_WIDTH-1])
                        r = -r;
                end
            end
            trae_pkg::OP_AND: r = a & b;
            trae_pkg::OP_OR:  r = a | b;
            default: begin
                r = a;
                wr = 1'b0;
            end
        endcase
        if (dvalid && wr)
            shadow_regs[it.dest_reg] = r;
        wb.dest_value = dvalid ? shadow_regs[it.dest_reg] : '0;
        wb.divide_error = err;
        return wb;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 9))
            0: return INT_MIN;
            1: return INT_MAX;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            4: return 32'h1;
            5, 6: return $urandom_range(0, 200) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] random_reg();
        return ($urandom_range(0, 19) == 0) ? R_NONE : 2'($urandom_range(0, 2));
    endfunction

    function automatic instr_t random_instr(bit div_heavy);
        logic [2:0] kind;
        if (div_heavy && $urandom_range(0, 9) < 8)
            kind = trae_pkg::OP_DIV;
        else if ($urandom_range(0, 99) < 3)
            kind = OP_UNUSED;
        else
            kind = 3'($urandom_range(0, 6));
        return make_instr(kind, random_reg(), 1'($urandom_range(0, 1)), random_reg(),
                          random_operand());
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("%0t MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Offer one transaction and hold it until accepted; gaps follow random bursts unless sender_steady is set
    task automatic send_instr(instr_t it);
        int gap;
        s_valid <= 1'b1;
        s_kind <= it.kind;
        s_dest_reg <= it.dest_reg;
        s_src_is_reg <= it.src_is_reg;
        s_src_reg <= it.src_reg;
        s_immediate <= it.immediate;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_writebacks.push_back(execute_instr(it));
        if (sender_steady)
            return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 40);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Drop valid so the last payload is not taken again
    task automatic sender_rest();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_for_drain();
        while (pending_writebacks.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_instr(make_instr(trae_pkg::OP_MOV, R1, SRC_IMM, R1, INT_MAX));
        send_instr(make_instr(trae_pkg::OP_ADD, R1, SRC_IMM, R1, 32'h1));
        send_instr(make_instr(trae_pkg::OP_MOV, R2, SRC_IMM, R1, 32'hffff_ffff));
        send_instr(make_instr(trae_pkg::OP_MUL, R1, SRC_REG, R2, 32'h0));
        send_instr(make_instr(trae_pkg::OP_DIV, R1, SRC_REG, R2, 32'h0));
        send_instr(make_instr(trae_pkg::OP_MOV, R3, SRC_IMM, R1, INT_MIN));
        send_instr(make_instr(trae_pkg::OP_SUB, R3, SRC_IMM, R1, 32'h1));
        send_instr(make_instr(trae_pkg::OP_DIV, R3, SRC_IMM, R1, 32'h0));
        send_instr(make_instr(trae_pkg::OP_MOV, R2, SRC_IMM, R1, 32'h0));
        send_instr(make_instr(trae_pkg::OP_DIV, R1, SRC_REG, R2, 32'h5555_5555));
        send_instr(make_instr(trae_pkg::OP_MOV, R1, SRC_IMM, R1, -32'sd7));
        send_instr(make_instr(trae_pkg::OP_DIV, R1, SRC_IMM, R1, 32'h2));
        send_instr(make_instr(trae_pkg::OP_DIV, R1, SRC_IMM, R1, -32'sd2));
        send_instr(make_instr(trae_pkg::OP_MOV, R2, SRC_IMM, R1, 32'ha5a5_a5a5));
        send_instr(make_instr(trae_pkg::OP_AND, R2, SRC_IMM, R1, 32'h0f0f_0f0f));
        send_instr(make_instr(trae_pkg::OP_OR, R2, SRC_IMM, R1, 32'hf000_0000));
        send_instr(make_instr(OP_UNUSED, R2, SRC_REG, R3, 32'hffff_ffff));
        send_instr(make_instr(trae_pkg::OP_MOV, R_NONE, SRC_IMM, R1, 32'h5));
        send_instr(make_instr(trae_pkg::OP_DIV, R_NONE, SRC_IMM, R1, 32'h0));
        send_instr(make_instr(trae_pkg::OP_DIV, R_NONE, SRC_IMM, R1, 32'h3));
        send_instr(make_instr(trae_pkg::OP_MOV, R1, SRC_REG, R_NONE, 32'hffff_ffff));
        send_instr(make_instr(trae_pkg::OP_ADD, R3, SRC_REG, R3, 32'h0));
        send_instr(make_instr(trae_pkg::OP_MOV, R1, SRC_IMM, R3, 32'hffff_ffff));
        send_instr(make_instr(trae_pkg::OP_MUL, R3, SRC_IMM, R2, INT_MAX));
        sender_rest();
    endtask

    task automatic test_random_mix(int count);
        repeat (count) send_instr(random_instr(1'b0));
        sender_rest();
    endtask

    task automatic test_divide_mix(int count);
        repeat (count) send_instr(random_instr(1'b1));
        sender_rest();
    endtask

    // Hold the result side off while the sender keeps offering back to back
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        sender_steady = 1'b1;
        repeat (12) send_instr(random_instr(1'b0));
        sender_steady = 1'b0;
        sender_rest();
    endtask

    // Let every result come back after each group
    task automatic test_drain_pauses();
        repeat (10) begin
            repeat ($urandom_range(1, 8)) send_instr(random_instr(1'b0));
            sender_rest();
            wait_for_drain();
        end
    endtask

    // Result side: check each accepted transaction and set the stall pattern
    always @(posedge aclk) begin
        writeback_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_writebacks.size() == 0) begin
                    report_mismatch("unexpected result", m_dest_value, '0);
                end else begin
                    want = pending_writebacks.pop_front();
                    if (m_dest_value !== want.dest_value)
                        report_mismatch("dest_value", m_dest_value, want.dest_value);
                    if (m_divide_error !== want.divide_error)
                        report_mismatch("divide_error", 32'(m_divide_error),
                                        32'(want.divide_error));
                end
            end
            if (stall_mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_mode_left = $urandom_range(20, 200);
            end else begin
                stall_mode_left--;
            end
            stall_phase = (stall_phase + 1) % 7;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
                m_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (stall_phase < 3);
                endcase
            end
        end
    end

    // Abort when no transaction moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_mix(600);
        test_output_backpressure();
        test_drain_pauses();
        test_divide_mix(300);
        wait_for_drain();
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
